// ===== design/pbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Perceptron branch predictor package
// Sizes, register indexes, stream layouts and shared types of the predictor.
// ----------------------------------------------------------------------------
package pbp_pkg;

  // Predictor geometry.
  localparam int HISTORY_LEN    = 32;
  localparam int ROW_INDEX_BITS = 8;
  localparam int WEIGHT_BITS    = 8;

  localparam int ROW_COUNT = 1 << ROW_INDEX_BITS;
  localparam int ROW_LEN   = HISTORY_LEN + 1;
  localparam int ROW_W     = ROW_LEN * WEIGHT_BITS;

  // Weight range of a signed WEIGHT_BITS value.
  localparam int W_MAX = (1 << (WEIGHT_BITS - 1)) - 1;
  localparam int W_MIN = -(1 << (WEIGHT_BITS - 1));

  // Adder tree: groups of GROUP terms summed in the first stage.
  localparam int GROUP  = 8;
  localparam int NGROUP = (ROW_LEN + GROUP - 1) / GROUP;
  localparam int TERM_W = WEIGHT_BITS + 1;
  localparam int PART_W = TERM_W + $clog2(GROUP);

  // Full sum width and the reported (saturated) field width.
  localparam int SUM_W       = WEIGHT_BITS + 1 + $clog2(ROW_LEN);
  localparam int SUM_OUT_W   = 14;
  localparam int SUMX_W      = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int SUM_OUT_MAX = 8191;
  localparam int SUM_OUT_MIN = -8192;

  // Configuration registers.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int THR_W      = 13;
  localparam int WUP_W      = 7;
  localparam int WLO_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W_UPPER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W_LOWER   = 2'd2;

  localparam logic [THR_W-1:0]        THR_RESET = 13'd76;
  localparam logic [WUP_W-1:0]        WUP_RESET = 7'd127;
  localparam logic signed [WLO_W-1:0] WLO_RESET = -8'sd128;

  // Stream layouts.
  localparam int S_TDATA_W   = 40;  // branch_pc[31:0], taken_outcome[32], zero pad
  localparam int PC_W        = 32;
  localparam int TAKEN_BIT   = 32;
  localparam int M_TDATA_W   = 16;  // predict_taken, perceptron_sum, weights_updated

  // Types.
  typedef logic signed [WEIGHT_BITS-1:0]     weight_t;
  typedef logic signed [TERM_W-1:0]          term_t;
  typedef logic signed [PART_W-1:0]          part_t;
  typedef logic signed [SUMX_W-1:0]          sumx_t;
  typedef logic signed [16:0]                lim_t;
  typedef logic [ROW_LEN-1:0][WEIGHT_BITS-1:0] row_t;

  typedef struct packed {
    logic                      mode;
    logic                      taken;
    logic [ROW_INDEX_BITS-1:0] row;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

endpackage

// ===== design/pbp_ram.sv =====
// ----------------------------------------------------------------------------
// Perceptron branch predictor RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/perceptron_branch_predictor_top.sv =====
// ----------------------------------------------------------------------------
// Perceptron branch predictor, global history
// Row-wide weight RAM, two-stage adder tree and trained write-back.
// ----------------------------------------------------------------------------
// An item passes through a sum state and a finish state. The cycle after
// the input beat reads one whole weight row from the RAM and forms partial
// sums plus the trained row; the finish state completes the sum, writes the
// row back and loads the result beat, while the next input beat is taken. A
// row that is written at the same edge as the next beat reads it is
// forwarded from the write data. The weight table clears instantly at reset
// through one valid bit per row (a row not yet written reads as all zero),
// so no clearing pass runs. A result beat waits in an output register; the
// block stalls in its last cycle only while that register is full and not
// taken. Configuration writes go straight to the registers and are meant
// for idle periods.
module perceptron_branch_predictor_top
  import pbp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // branch_pc[31:0], taken_outcome[32]
  input  logic [0:0]            s_axis_tuser,  // mode[0]
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata   // predict_taken[0],
                                               // perceptron_sum[14:1],
                                               // weights_updated[15]
);

  // Configuration registers.
  logic [THR_W-1:0]        thr_q;
  logic [WUP_W-1:0]        wup_q;
  logic signed [WLO_W-1:0] wlo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      wup_q <= WUP_RESET;
      wlo_q <= WLO_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        CFG_W_UPPER:   wup_q <= cfg_data_i[WUP_W-1:0];
        CFG_W_LOWER:   wlo_q <= cfg_data_i[WLO_W-1:0];
        default: ;
      endcase
    end
  end

  // Limits clamped into what a weight can hold.
  function automatic weight_t lim_to_weight(lim_t v);
    weight_t r;
    if (v > lim_t'(W_MAX)) begin
      r = weight_t'(W_MAX);
    end else if (v < lim_t'(W_MIN)) begin
      r = weight_t'(W_MIN);
    end else begin
      r = v[WEIGHT_BITS-1:0];
    end
    return r;
  endfunction

  // One training step: move by one, then limit to hi and raise to lo.
  function automatic weight_t train_weight(weight_t old, logic up, weight_t lo, weight_t hi);
    term_t v;
    term_t r;
    v = up ? (term_t'(old) + term_t'(1)) : (term_t'(old) - term_t'(1));
    r = v;
    if (r > term_t'(hi)) r = term_t'(hi);
    if (r < term_t'(lo)) r = term_t'(lo);
    return r[WEIGHT_BITS-1:0];
  endfunction

  weight_t w_hi;
  weight_t w_lo;

  assign w_hi = lim_to_weight(lim_t'(signed'({1'b0, wup_q})));
  assign w_lo = lim_to_weight(lim_t'(wlo_q));

  // Control and handshake.
  state_e state_q, state_d;
  logic   s_acc;
  logic   fin_go;
  logic   m_valid_q;

  assign fin_go        = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || fin_go;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_acc) state_d = ST_SUM;
      ST_SUM:  state_d = ST_FIN;
      ST_FIN: begin
        if (fin_go) state_d = s_acc ? ST_SUM : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Item captured on the input beat.
  item_t                     item_q;
  logic [ROW_INDEX_BITS-1:0] in_row;

  assign in_row = s_axis_tdata[ROW_INDEX_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q.mode  <= s_axis_tuser[0];
      item_q.taken <= s_axis_tdata[TAKEN_BIT];
      item_q.row   <= in_row;
    end
  end

  // Weight RAM with per-row valid bits and same-row forwarding.
  logic                 ram_we;
  logic [ROW_W-1:0]     ram_rdata;
  row_t                 nrow_q;
  logic [ROW_COUNT-1:0] valid_q;
  logic                 rvalid_q;
  logic                 fwd_q;

  pbp_ram #(
    .Width (ROW_W),
    .Depth (ROW_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_q.row),
    .wdata_i (nrow_q),
    .re_i    (s_acc),
    .raddr_i (in_row),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (ram_we) valid_q[item_q.row] <= 1'b1;
      if (s_acc) begin
        rvalid_q <= valid_q[in_row];
        fwd_q    <= ram_we && (item_q.row == in_row);
      end
    end
  end

  // Global history, newest outcome in bit 0.
  logic [HISTORY_LEN-1:0] hist_q;

  // First stage: signed terms, partial sums of each group, trained row.
  row_t  cur_row;
  term_t terms [NGROUP*GROUP];
  part_t part_d [NGROUP];
  part_t part_q [NGROUP];
  row_t  nrow_d;
  logic  chg_d;
  logic  chg_q;

  always_comb begin
    weight_t w;
    weight_t nw;
    logic    up;
    if (fwd_q) begin
      cur_row = nrow_q;
    end else if (rvalid_q) begin
      cur_row = row_t'(ram_rdata);
    end else begin
      cur_row = '0;
    end

    for (int i = 0; i < NGROUP*GROUP; i++) terms[i] = '0;
    chg_d  = 1'b0;
    nrow_d = cur_row;

    for (int i = 0; i < HISTORY_LEN; i++) begin
      w        = cur_row[i];
      terms[i] = hist_q[i] ? term_t'(w) : -term_t'(w);
      up       = ~(item_q.taken ^ hist_q[i]);
      nw       = train_weight(w, up, w_lo, w_hi);
      nrow_d[i] = nw;
      if (nw != w) chg_d = 1'b1;
    end

    // Bias weight: always counted positive, trained toward the outcome.
    w                  = cur_row[HISTORY_LEN];
    terms[HISTORY_LEN] = term_t'(w);
    nw                 = train_weight(w, item_q.taken, w_lo, w_hi);
    nrow_d[HISTORY_LEN] = nw;
    if (nw != w) chg_d = 1'b1;

    for (int g = 0; g < NGROUP; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        part_d[g] = part_d[g] + part_t'(terms[g*GROUP + k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      part_q <= part_d;
      nrow_q <= nrow_d;
      chg_q  <= chg_d;
    end
  end

  // Second stage: full sum, prediction, training decision.
  sumx_t sum;
  sumx_t mag;
  sumx_t sum_c;
  logic  pred;
  logic  train;

  always_comb begin
    sum = '0;
    for (int g = 0; g < NGROUP; g++) sum = sum + sumx_t'(part_q[g]);
    pred  = ~sum[SUMX_W-1];
    mag   = sum[SUMX_W-1] ? -sum : sum;
    train = item_q.mode &&
            ((pred != item_q.taken) ||
             ($unsigned(mag) < {{(SUMX_W-THR_W){1'b0}}, thr_q}));
    if (sum > sumx_t'(SUM_OUT_MAX)) begin
      sum_c = sumx_t'(SUM_OUT_MAX);
    end else if (sum < sumx_t'(SUM_OUT_MIN)) begin
      sum_c = sumx_t'(SUM_OUT_MIN);
    end else begin
      sum_c = sum;
    end
  end

  assign ram_we = fin_go && train;

  // History update, state and result register.
  logic [M_TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hist_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go && item_q.mode) begin
        hist_q <= (hist_q << 1) | HISTORY_LEN'(item_q.taken);
      end
      if (fin_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      m_data_q <= {train && chg_q, sum_c[SUM_OUT_W-1:0], pred};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  a_we_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_FIN) && item_q.mode)
    else $error("weight row written outside the finish cycle of a training beat");

  a_acc_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q == ST_SUM))
    else $error("accepted beat did not move into the sum stage");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result beat appeared without a finished item");

  a_fwd_after_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(ram_we))
    else $error("forwarding armed without a row write");
`endif

endmodule
